[hw/rtl/blup_pkg.sv]
// Shared types and constants of the 2x bilinear upscaler.
// Payload widths, register indexes and the job record between intake and emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blup_pkg;

  // default limits of the stores
  localparam int MAX_WIDTH_DEF    = 256;
  localparam int MAX_CHANNELS_DEF = 32;
  localparam int HEIGHT_LIMIT     = 4096;

  // payload widths
  localparam int SAMPLE_W     = 8;
  localparam int ROW_W        = 13;
  localparam int COL_W        = 9;
  localparam int CHAN_W       = 5;
  localparam int YW           = 12;
  localparam int JX_W         = COL_W - 1;
  localparam int QCNT_W       = 2;
  localparam int MASK_W       = 4;

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 13;
  localparam int CHAN_REG_W   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 2'd2;

  // block positions relative to the current input pixel, in emission order
  localparam int BLK_UP_LEFT = 0;  // (y-1, x-1)
  localparam int BLK_UP      = 1;  // (y-1, x), last column only
  localparam int BLK_LEFT    = 2;  // (y, x-1), last row only
  localparam int BLK_SELF    = 3;  // (y, x), last row and last column

  // one input's worth of work for the emitter
  typedef struct packed {
    logic [YW-1:0]       y;
    logic [JX_W-1:0]     x;
    logic [CHAN_W-1:0]   ch;
    logic [SAMPLE_W-1:0] ul;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] lf;
    logic [SAMPLE_W-1:0] s;
    logic [MASK_W-1:0]   mask;
    logic                lof;
  } job_t;

endpackage

`default_nettype wire

[hw/rtl/blup_in_if.sv]
// Input sample channel: valid/ready plus one 8-bit sample.
// Depends on blup_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blup_in_if import blup_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/blup_out_if.sv]
// Result channel: valid/ready plus one output sample with its position and flags.
// Depends on blup_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blup_out_if import blup_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    out_col;
  logic [CHAN_W-1:0]   chan;
  logic [SAMPLE_W-1:0] pixel_value;
  logic                last_of_run;
  logic                frame_done;

  modport source (output valid, output out_row, output out_col, output chan,
                  output pixel_value, output last_of_run, output frame_done,
                  input ready);
  modport sink   (input valid, input out_row, input out_col, input chan,
                  input pixel_value, input last_of_run, input frame_done,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/blup_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on blup_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blup_cfg_if import blup_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/blup_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module blup_ram #(
  parameter  int DW    = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/blup_intake.sv]
// Intake stage: position counters, row and left-pixel memories with forwarding,
// and assembly of one job per input sample. Depends on blup_pkg, blup_ram, blup_in_if.
`timescale 1ns / 1ps
`default_nettype none

module blup_intake import blup_pkg::*; #(
  parameter  int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int AW  = (MAX_WIDTH * MAX_CHANNELS > 1) ? $clog2(MAX_WIDTH * MAX_CHANNELS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  blup_in_if.sink                in_if,
  input  wire logic              restart,
  input  wire logic [XW-1:0]     w_last,
  input  wire logic [YW-1:0]     h_last,
  input  wire logic [CHW-1:0]    nc_last,
  input  wire logic [QCNT_W-1:0] q_cnt,
  output logic                   job_push,
  output job_t                   job
);

  localparam int LW = 2 * SAMPLE_W;

  logic           in_fire;
  logic           end_ch;
  logic           end_row;
  logic           last_col;
  logic           last_row;
  logic [MASK_W-1:0] mask_now;

  logic [CHW-1:0] ch_r, ch_nxt;
  logic [XW-1:0]  x_r, x_nxt;
  logic [YW-1:0]  y_r, y_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;

  logic                s1_vld_r;
  logic [SAMPLE_W-1:0] s1_s_r;
  logic [AW-1:0]       s1_idx_r;
  logic [CHW-1:0]      s1_ch_r;
  logic [XW-1:0]       s1_x_r;
  logic [YW-1:0]       s1_y_r;
  logic [MASK_W-1:0]   s1_mask_r;
  logic                s1_lof_r;

  logic                fw_vld_r;
  logic [AW-1:0]       fw_row_addr_r;
  logic [SAMPLE_W-1:0] fw_row_data_r;
  logic [CHW-1:0]      fw_left_addr_r;
  logic [LW-1:0]       fw_left_data_r;

  logic [SAMPLE_W-1:0] row_rdata;
  logic [LW-1:0]       left_rdata;
  logic [SAMPLE_W-1:0] up;
  logic [LW-1:0]       left_val;

  // intake flow control: a stage-1 request with pending blocks always moves into the job queue
  assign in_if.ready = s1_vld_r ? (q_cnt == '0) : (q_cnt != QCNT_W'(2));
  assign in_fire     = in_if.valid && in_if.ready;

  // position decode of the current request
  assign end_ch   = (ch_r == nc_last);
  assign last_col = (x_r == w_last);
  assign last_row = (y_r == h_last);
  assign end_row  = end_ch && last_col;

  always_comb begin
    mask_now              = '0;
    mask_now[BLK_UP_LEFT] = (y_r != '0) && (x_r != '0);
    mask_now[BLK_UP]      = (y_r != '0) && last_col;
    mask_now[BLK_LEFT]    = last_row && (x_r != '0);
    mask_now[BLK_SELF]    = last_row && last_col;
  end

  // raster counters and running row address
  always_comb begin
    ch_nxt  = ch_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    idx_nxt = idx_r;
    if (restart) begin
      ch_nxt  = '0;
      x_nxt   = '0;
      y_nxt   = '0;
      idx_nxt = '0;
    end else if (in_fire) begin
      idx_nxt = end_row ? '0 : idx_r + AW'(1);
      if (end_ch) begin
        ch_nxt = '0;
        if (last_col) begin
          x_nxt = '0;
          y_nxt = last_row ? '0 : y_r + YW'(1);
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end else begin
        ch_nxt = ch_r + CHW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      x_r   <= '0;
      y_r   <= '0;
      idx_r <= '0;
    end else begin
      ch_r  <= ch_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      idx_r <= idx_nxt;
    end
  end

  // stage 1 holds the request while the memories answer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_s_r    <= in_if.sample;
      s1_idx_r  <= idx_r;
      s1_ch_r   <= ch_r;
      s1_x_r    <= x_r;
      s1_y_r    <= y_r;
      s1_mask_r <= mask_now;
      s1_lof_r  <= end_row && last_row;
    end
  end

  // previous input row, one entry per column and channel
  blup_ram #(
    .DW    (SAMPLE_W),
    .DEPTH (MAX_WIDTH * MAX_CHANNELS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_idx_r),
    .wdata (s1_s_r),
    .re    (in_fire),
    .raddr (idx_r),
    .rdata (row_rdata)
  );

  // left pixels of the current row and the row above, one entry per channel
  blup_ram #(
    .DW    (LW),
    .DEPTH (MAX_CHANNELS)
  ) u_left_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_ch_r),
    .wdata ({up, s1_s_r}),
    .re    (in_fire),
    .raddr (ch_r),
    .rdata (left_rdata)
  );

  // forward the write that landed on the same edge as this read
  assign up       = (fw_vld_r && (fw_row_addr_r == s1_idx_r)) ? fw_row_data_r : row_rdata;
  assign left_val = (fw_vld_r && (fw_left_addr_r == s1_ch_r)) ? fw_left_data_r : left_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_vld_r <= 1'b0;
    end else if (s1_vld_r) begin
      fw_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      fw_row_addr_r  <= s1_idx_r;
      fw_row_data_r  <= s1_s_r;
      fw_left_addr_r <= s1_ch_r;
      fw_left_data_r <= {up, s1_s_r};
    end
  end

  // job record for the emitter
  always_comb begin
    job      = '0;
    job.y    = s1_y_r;
    job.x    = JX_W'(s1_x_r);
    job.ch   = CHAN_W'(s1_ch_r);
    job.ul   = left_val[LW-1:SAMPLE_W];
    job.lf   = left_val[SAMPLE_W-1:0];
    job.up   = up;
    job.s    = s1_s_r;
    job.mask = s1_mask_r;
    job.lof  = s1_lof_r;
  end

  assign job_push = s1_vld_r && (s1_mask_r != '0);

endmodule

`default_nettype wire

[hw/rtl/blup_emit.sv]
// Emitter: two-entry job queue and result sequencer into the output register.
// Each job yields up to four 2x2 blocks. Depends on blup_pkg, blup_out_if.
`timescale 1ns / 1ps
`default_nettype none

module blup_emit import blup_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_push,
  input  wire job_t              job_in,
  output logic [QCNT_W-1:0]      q_cnt,
  blup_out_if.source             out_if
);

  job_t              q_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        sub_r;

  job_t                head;
  logic                head_vld;
  logic                load;
  logic                blk_done;
  logic                pop;
  logic [MASK_W-1:0]   blk_sel;
  logic [MASK_W-1:0]   rem_mask;
  logic [SAMPLE_W-1:0] a, rt, lo, lr;
  logic [YW-1:0]       r;
  logic [JX_W-1:0]     c;
  logic [SAMPLE_W:0]   sum2;
  logic [SAMPLE_W+1:0] sum4;
  logic [SAMPLE_W-1:0] pix;

  logic                out_vld_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [CHAN_W-1:0]   out_chan_r;
  logic [SAMPLE_W-1:0] out_pix_r;
  logic                out_last_r;
  logic                out_frame_r;

  assign head     = q_r[rd_ptr_r];
  assign head_vld = (cnt_r != '0);
  assign q_cnt    = cnt_r;

  // lowest pending block of the head job
  always_comb begin
    blk_sel = '0;
    if (head.mask[BLK_UP_LEFT]) begin
      blk_sel[BLK_UP_LEFT] = 1'b1;
    end else if (head.mask[BLK_UP]) begin
      blk_sel[BLK_UP] = 1'b1;
    end else if (head.mask[BLK_LEFT]) begin
      blk_sel[BLK_LEFT] = 1'b1;
    end else begin
      blk_sel[BLK_SELF] = 1'b1;
    end
  end

  // corner samples and block position
  always_comb begin
    a  = head.s;
    rt = head.s;
    lo = head.s;
    lr = head.s;
    r  = head.y;
    c  = head.x;
    if (blk_sel[BLK_UP_LEFT]) begin
      a  = head.ul;
      rt = head.up;
      lo = head.lf;
      r  = head.y - YW'(1);
      c  = head.x - JX_W'(1);
    end else if (blk_sel[BLK_UP]) begin
      a  = head.up;
      rt = head.up;
      r  = head.y - YW'(1);
    end else if (blk_sel[BLK_LEFT]) begin
      a  = head.lf;
      lo = head.lf;
      c  = head.x - JX_W'(1);
    end
  end

  // interpolation of the selected corner of the block
  assign sum2 = {1'b0, a} + {1'b0, (sub_r[1] ? lo : rt)} + (SAMPLE_W+1)'(1);
  assign sum4 = {2'b00, a} + {2'b00, rt} + {2'b00, lo} + {2'b00, lr} + (SAMPLE_W+2)'(2);

  always_comb begin
    case (sub_r)
      2'd0:    pix = a;
      2'd1:    pix = sum2[SAMPLE_W:1];
      2'd2:    pix = sum2[SAMPLE_W:1];
      2'd3:    pix = sum4[SAMPLE_W+1:2];
      default: pix = a;
    endcase
  end

  // sequencing
  assign load     = head_vld && (!out_vld_r || out_if.ready);
  assign blk_done = load && (sub_r == 2'd3);
  assign rem_mask = head.mask & ~blk_sel;
  assign pop      = blk_done && (rem_mask == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    case ({job_push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
      sub_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (job_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (load) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  // queue storage; the head mask drops each finished block
  always_ff @(posedge clk) begin
    if (job_push) begin
      q_r[wr_ptr_r] <= job_in;
    end
    if (blk_done) begin
      q_r[rd_ptr_r].mask <= rem_mask;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r   <= {r, sub_r[1]};
      out_col_r   <= {c, sub_r[0]};
      out_chan_r  <= head.ch;
      out_pix_r   <= pix;
      out_last_r  <= pop;
      out_frame_r <= pop && head.lof;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.out_row     = out_row_r;
  assign out_if.out_col     = out_col_r;
  assign out_if.chan        = out_chan_r;
  assign out_if.pixel_value = out_pix_r;
  assign out_if.last_of_run = out_last_r;
  assign out_if.frame_done  = out_frame_r;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (cnt_r != QCNT_W'(2)))
    else $error("job pushed into a full queue");

  a_head_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld |-> (head.mask != '0))
    else $error("queued job without pending blocks");

  a_idle_sub: assert property (@(posedge clk) disable iff (!rst_n)
    !head_vld |-> (sub_r == 2'd0))
    else $error("corner counter not aligned at empty queue");

  a_frame_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_frame_r) |-> out_last_r)
    else $error("frame end flagged on a result that does not close its request");

endmodule

`default_nettype wire

[hw/rtl/bilinear_upscale_2x_top.sv]
// Top level of the 2x bilinear upscaler: configuration registers, intake and emitter.
// Depends on blup_pkg, the channel interfaces, blup_intake, blup_emit.
//
//  channel | dir | payload                                             | moves on
//  in_if   | in  | sample                                              | valid & ready
//  out_if  | out | out_row, out_col, chan, pixel_value, last_of_run,   | valid & ready
//          |     | frame_done                                          |
//  cfg_if  | in  | index, data                                         | valid (ready tied high)
//
// A sample is read out of the row and left-pixel memories in the cycle after it is
// taken, and its results pass through the job queue into the output register.
// Results leave at one per cycle while out_if is ready; a sample that closes k blocks
// yields 4k results on the output port. Samples that close no block are taken every
// cycle while the job queue is empty.
// A two-entry job queue lets intake run ahead while out_if is stalled.
// Reset is synchronous, active low; the memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_upscale_2x_top import blup_pkg::*; #(
  parameter  int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  blup_in_if.sink   in_if,
  blup_out_if.source out_if,
  blup_cfg_if.sink  cfg_if
);

  logic                    cfg_fire;
  logic                    restart;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;
  logic [CHAN_REG_W-1:0]   cfg_c;
  logic [XW-1:0]           w_last_r, w_last_nxt;
  logic [YW-1:0]           h_last_r, h_last_nxt;
  logic [CHW-1:0]          nc_last_r, nc_last_nxt;
  logic [QCNT_W-1:0]       q_cnt;
  logic                    job_push;
  job_t                    job;

  // configuration writes are always taken
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;
  assign cfg_w        = cfg_if.data[WIDTH_REG_W-1:0];
  assign cfg_h        = cfg_if.data[HEIGHT_REG_W-1:0];
  assign cfg_c        = cfg_if.data[CHAN_REG_W-1:0];

  assign restart = cfg_fire && ((cfg_if.index == REG_IN_WIDTH) ||
                                (cfg_if.index == REG_IN_HEIGHT) ||
                                (cfg_if.index == REG_CHANNELS));

  // clamp the written value and keep it as a last-position compare value
  always_comb begin
    w_last_nxt  = w_last_r;
    h_last_nxt  = h_last_r;
    nc_last_nxt = nc_last_r;
    if (cfg_fire) begin
      case (cfg_if.index)
        REG_IN_WIDTH: begin
          if (cfg_w == '0) begin
            w_last_nxt = '0;
          end else if ({4'b0000, cfg_w} > 13'(MAX_WIDTH)) begin
            w_last_nxt = XW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = XW'(cfg_w - WIDTH_REG_W'(1));
          end
        end
        REG_IN_HEIGHT: begin
          if (cfg_h == '0) begin
            h_last_nxt = '0;
          end else if (cfg_h > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
            h_last_nxt = YW'(HEIGHT_LIMIT - 1);
          end else begin
            h_last_nxt = YW'(cfg_h - HEIGHT_REG_W'(1));
          end
        end
        REG_CHANNELS: begin
          if (cfg_c == '0) begin
            nc_last_nxt = '0;
          end else if ({4'b0000, cfg_c} > 10'(MAX_CHANNELS)) begin
            nc_last_nxt = CHW'(MAX_CHANNELS - 1);
          end else begin
            nc_last_nxt = CHW'(cfg_c - CHAN_REG_W'(1));
          end
        end
        default: begin
          w_last_nxt = w_last_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= '0;
      h_last_r  <= '0;
      nc_last_r <= '0;
    end else begin
      w_last_r  <= w_last_nxt;
      h_last_r  <= h_last_nxt;
      nc_last_r <= nc_last_nxt;
    end
  end

  // counters, memories and job assembly
  blup_intake #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_intake (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .restart  (restart),
    .w_last   (w_last_r),
    .h_last   (h_last_r),
    .nc_last  (nc_last_r),
    .q_cnt    (q_cnt),
    .job_push (job_push),
    .job      (job)
  );

  // result sequencing
  blup_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_push (job_push),
    .job_in   (job),
    .q_cnt    (q_cnt),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire
